### rtl/assert_macros.svh
// Assertion macros for the Fresnel reflectance checker.
// Used by fdr_checker.sv only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define FDR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fdr assertion failed");

// Clocked assertion that also holds through reset.
`define FDR_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fdr assertion failed");

`endif

### rtl/fdr_pkg.sv
// Shared types and constants for the Fresnel reflectance pipeline.
// No dependencies.
package fdr_pkg;

  localparam int SqrtCells = 20;   // root bits of a 40-bit radicand
  localparam int DivCells  = 17;   // quotient bits, clamped later to 0..65536
  localparam logic [16:0] One16 = 17'd65536;

  // sqrt chain payload
  typedef struct packed {
    logic [40:0] x;
    logic [40:0] r;
    logic        tir;
    logic [16:0] cc;
  } sq_t;

  // divider chain payload, two lanes
  typedef struct packed {
    logic [21:0] rem_a;
    logic [20:0] den_a;
    logic [16:0] q_a;
    logic [40:0] rem_b;
    logic [39:0] den_b;
    logic [16:0] q_b;
    logic        sat_b;
    logic        tir;
  } dv_t;

endpackage

### rtl/fdr_if.sv
// Request and result channel interfaces for the Fresnel reflectance block.
// No dependencies.
interface fdr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cos_incident;
  logic        [15:0] relative_ior;
  modport source (output valid, cos_incident, relative_ior, input ready);
  modport sink   (input valid, cos_incident, relative_ior, output ready);
endinterface

interface fdr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] reflectance;
  logic        total_internal;
  modport source (output valid, reflectance, total_internal, input ready);
  modport sink   (input valid, reflectance, total_internal, output ready);
endinterface

### rtl/fdr_sqrt_cell.sv
// One bit-pair step of the restoring square root chain.
// Depends on fdr_pkg.
module fdr_sqrt_cell import fdr_pkg::*; #(
  parameter int K = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  sq_t  in_data,
  output logic out_valid,
  output sq_t  out_data
);
  localparam logic [40:0] Bit = 41'(1) << (2 * K);

  logic [40:0] trial;
  sq_t         nxt;

  always_comb begin
    trial = in_data.r + Bit;
    nxt   = in_data;
    if (in_data.x >= trial) begin
      nxt.x = in_data.x - trial;
      nxt.r = (in_data.r >> 1) + Bit;
    end else begin
      nxt.r = in_data.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= nxt;
    end
  end
endmodule

### rtl/fdr_div_cell.sv
// One quotient bit of both restoring dividers (A and B lanes).
// Depends on fdr_pkg.
module fdr_div_cell import fdr_pkg::*; #(
  parameter bit FIRST = 1'b0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  dv_t  in_data,
  output logic out_valid,
  output dv_t  out_data
);
  logic [21:0] ra;
  logic [40:0] rb;
  logic        ga, gb;
  dv_t         nxt;

  always_comb begin
    ra  = FIRST ? in_data.rem_a : (in_data.rem_a << 1);
    rb  = FIRST ? in_data.rem_b : (in_data.rem_b << 1);
    ga  = ra >= {1'b0, in_data.den_a};
    gb  = rb >= {1'b0, in_data.den_b};
    nxt = in_data;
    nxt.rem_a = ga ? (ra - {1'b0, in_data.den_a}) : ra;
    nxt.rem_b = gb ? (rb - {1'b0, in_data.den_b}) : rb;
    nxt.q_a   = {in_data.q_a[15:0], ga};
    nxt.q_b   = {in_data.q_b[15:0], gb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= nxt;
    end
  end
endmodule

### rtl/fresnel_dielectric_reflectance_top.sv
// Top level of the unpolarized Fresnel reflectance pipeline.
// Depends on fdr_pkg, fdr_if, fdr_sqrt_cell, fdr_div_cell.
//
// Usage:
//   item   : request channel, cos_incident (signed Q1.15, magnitude used)
//            and relative_ior (unsigned Q4.12). Taken when valid && ready.
//   result : reflectance (Q0.16, 1.0 saturates to 65535) and
//            total_internal. Delivered when valid && ready.
// The stages are one squaring stage, 20 square-root cells,
// one stage of B products, 17 divider cells (A and B side by side),
// one squaring stage and the output register.
// Throughput is one request per cycle while not stalled; every stage
// holds its own item, so a request can enter with others in flight.
// The whole chain advances together; when the receiver stalls with a
// result waiting, the chain holds and item.ready drops in that cycle.
// Bubbles do not close up: every stage, empty or not, holds while the
// output register is full and not taken.
// Reset (synchronous, active high) clears all valid bits; the payload
// registers are not reset.
module fresnel_dielectric_reflectance_top import fdr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  fdr_in_if.sink           item,
  fdr_out_if.source        result
);
  // global advance: output register empty or being taken
  logic adv;
  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;

  // stage 1: magnitude of c, squares
  logic        s1_v;
  logic [31:0] s1_eta2;
  logic [30:0] s1_c2;
  logic [16:0] s1_cc;
  logic [16:0] c15;

  assign c15 = item.cos_incident[15] ? (17'd65536 - {1'b0, item.cos_incident})
                                     : {1'b0, item.cos_incident};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= item.valid;
    end
    if (adv) begin
      s1_eta2 <= {16'b0, item.relative_ior} * {16'b0, item.relative_ior};
      s1_c2   <= {14'b0, c15} * {14'b0, c15};
      s1_cc   <= {c15[15:0], 1'b0};
    end
  end

  // g in signed Q.30, radicand 4g feeds the root chain
  logic signed [39:0] g30;
  sq_t                sq_in;

  always_comb begin
    g30 = $signed({2'b00, s1_eta2, 6'b0}) + $signed({9'b0, s1_c2})
          - $signed(40'd1 << 30);
    sq_in.tir = g30[39] || (g30 == '0);
    sq_in.x   = sq_in.tir ? '0 : {g30[38:0], 2'b00};
    sq_in.r   = '0;
    sq_in.cc  = s1_cc;
  end

  // square root chain, bit pairs from the top down
  logic sq_v [SqrtCells+1];
  sq_t  sq_d [SqrtCells+1];
  assign sq_v[0] = s1_v;
  assign sq_d[0] = sq_in;

  for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
    fdr_sqrt_cell #(.K(SqrtCells - 1 - i)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(sq_v[i]), .in_data(sq_d[i]),
      .out_valid(sq_v[i+1]), .out_data(sq_d[i+1])
    );
  end

  // stage M: sums and the B products
  logic [19:0]        gs;
  logic [16:0]        cm;
  logic signed [20:0] gmc;
  logic               m_v, m_tir;
  logic [20:0]        m_sum, m_adiff;
  logic [37:0]        m_pa;
  logic signed [38:0] m_pb;

  assign gs  = sq_d[SqrtCells].r[19:0];
  assign cm  = sq_d[SqrtCells].cc;
  assign gmc = $signed({1'b0, gs}) - $signed({4'b0, cm});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= sq_v[SqrtCells];
    end
    if (adv) begin
      m_tir   <= sq_d[SqrtCells].tir;
      m_sum   <= {1'b0, gs} + {4'b0, cm};
      m_adiff <= (gs >= {3'b0, cm}) ? ({1'b0, gs} - {4'b0, cm})
                                    : ({4'b0, cm} - {1'b0, gs});
      m_pa    <= {21'b0, cm} * {17'b0, ({1'b0, gs} + {4'b0, cm})};
      m_pb    <= 39'($signed({1'b0, cm})) * 39'(gmc);
    end
  end

  // divider set-up
  logic signed [39:0] bnum, bden;
  logic [39:0]        bmag;
  logic               bsat;
  dv_t                dv_in;

  always_comb begin
    bnum = $signed({2'b00, m_pa}) - $signed(40'd1 << 32);
    bden = 40'(m_pb) + $signed(40'd1 << 32);
    bmag = bnum[39] ? 40'(-bnum) : bnum;
    bsat = bden[39] || (bden == '0) || ({1'b0, bmag} >= {bden, 1'b0});
    dv_in.rem_a = {1'b0, m_adiff};
    dv_in.den_a = m_sum;
    dv_in.q_a   = '0;
    dv_in.rem_b = bsat ? '0 : {1'b0, bmag};
    dv_in.den_b = bsat ? 40'd1 : bden;
    dv_in.q_b   = '0;
    dv_in.sat_b = bsat;
    dv_in.tir   = m_tir;
  end

  // divider chain, one quotient bit per cell for both lanes
  logic dv_v [DivCells+1];
  dv_t  dv_d [DivCells+1];
  assign dv_v[0] = m_v;
  assign dv_d[0] = dv_in;

  for (genvar i = 0; i < DivCells; i++) begin : g_div
    fdr_div_cell #(.FIRST(i == 0)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(dv_v[i]), .in_data(dv_d[i]),
      .out_valid(dv_v[i+1]), .out_data(dv_d[i+1])
    );
  end

  // stage Q: squares of A and B
  logic [16:0] qa, qb;
  logic [33:0] asq, bsq;
  logic        q_v, q_tir;
  logic [17:0] q_a2, q_b2;

  always_comb begin
    qa  = (dv_d[DivCells].q_a > One16) ? One16 : dv_d[DivCells].q_a;
    qb  = (dv_d[DivCells].sat_b || dv_d[DivCells].q_b > One16) ? One16
                                                               : dv_d[DivCells].q_b;
    asq = {17'b0, qa} * {17'b0, qa};
    bsq = {17'b0, qb} * {17'b0, qb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else if (adv) begin
      q_v <= dv_v[DivCells];
    end
    if (adv) begin
      q_tir <= dv_d[DivCells].tir;
      q_a2  <= asq[33:16];
      q_b2  <= bsq[33:16];
    end
  end

  // output stage: 0.5 * A^2 * (1 + B^2), saturated
  logic [18:0] pp;
  logic [36:0] prod;
  logic [19:0] rr;

  always_comb begin
    pp   = 19'd65536 + {1'b0, q_b2};
    prod = {19'b0, q_a2} * {18'b0, pp};
    rr   = prod[36:17];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= q_v;
    end
    if (adv) begin
      result.total_internal <= q_tir;
      result.reflectance    <= (q_tir || rr > 20'd65535) ? 16'hFFFF : rr[15:0];
    end
  end
endmodule

### rtl/fdr_checker.sv
// Port-level checks for the Fresnel reflectance block, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fdr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] reflectance,
  input logic        total_internal
);
  `FDR_ASSERT(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `FDR_ASSERT(a_stall_refl, clk, rst, out_valid && !out_ready |=> $stable(reflectance))
  `FDR_ASSERT(a_stall_tir, clk, rst, out_valid && !out_ready |=> $stable(total_internal))
  `FDR_ASSERT(a_tir_full, clk, rst, out_valid && total_internal |-> reflectance == 16'hFFFF)
  `FDR_ASSERT_RST(a_reset_empty, clk, rst |=> !out_valid)
endmodule

bind fresnel_dielectric_reflectance_top fdr_checker u_fdr_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .reflectance(result.reflectance),
  .total_internal(result.total_internal)
);

### test/tb_fresnel_dielectric_reflectance_top.sv
// Self-checking testbench for the Fresnel reflectance pipeline.
// Depends on fdr_pkg, fdr_if and fresnel_dielectric_reflectance_top.
// It drives random and corner requests and checks each result against an
// in-bench fixed-point prediction.
module tb_fresnel_dielectric_reflectance_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fdr_pkg::*;

  typedef struct {
    logic signed [15:0] cos_incident;
    logic        [15:0] relative_ior;
  } fresnel_req_t;

  typedef struct {
    logic [15:0] reflectance;
    logic        total_internal;
  } fresnel_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fdr_in_if  item ();
  fdr_out_if result ();

  fresnel_dielectric_reflectance_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  always #4 clk = ~clk;

  fresnel_req_t pending_reqs[$];   // requests not yet offered
  fresnel_res_t expected_refl[$];  // predictions awaiting their result
  int           n_total;           // number of requests queued at start
  int           n_sent;            // requests accepted so far
  int           n_errors;

  // Integer square root, floor, bit-pair method.
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Fixed-point Fresnel reflectance, all roundings toward zero.
  function automatic fresnel_res_t fresnel_reflectance(input fresnel_req_t rq);
    fresnel_res_t    res;
    longint unsigned raw, eta, c15, gs, cc, adiff, a, b, bmag, a2, p, r;
    longint          g30, bnum, bden;
    raw = {48'd0, rq.cos_incident};
    eta = {48'd0, rq.relative_ior};
    // magnitude of the cosine; the most negative code means 1.0
    c15 = raw[15] ? (64'd65536 - raw) : raw;
    g30 = longint'((eta * eta) << 6) + longint'(c15 * c15) - (64'sd1 <<< 30);
    if (g30 <= 0) begin
      res.reflectance    = 16'hFFFF;
      res.total_internal = 1'b1;
      return res;
    end
    gs    = floor_sqrt(longint'(g30) * 4);
    cc    = c15 << 1;
    adiff = (gs >= cc) ? (gs - cc) : (cc - gs);
    a     = (adiff << 16) / (gs + cc);
    if (a > 65536) a = 65536;
    bnum = longint'(cc * (gs + cc)) - (64'sd1 <<< 32);
    bden = longint'(cc) * (longint'(gs) - longint'(cc)) + (64'sd1 <<< 32);
    bmag = (bnum < 0) ? longint'(-bnum) : longint'(bnum);
    b    = 65536;
    if (bden > 0) begin
      b = (bmag << 16) / longint'(bden);
      if (b > 65536) b = 65536;
    end
    a2 = (a * a) >> 16;
    p  = 65536 + ((b * b) >> 16);
    // the extra shift folds in the factor one half
    r  = (a2 * p) >> 17;
    if (r > 65535) r = 65535;
    res.reflectance    = r[15:0];
    res.total_internal = 1'b0;
    return res;
  endfunction

  // Sender: random idle bursts except near the end of the run.
  int send_gap;
  always @(posedge clk) begin
    fresnel_req_t rq;
    if (rst) begin
      item.valid        <= 1'b0;
      item.cos_incident <= '0;
      item.relative_ior <= '0;
      send_gap          = 0;
    end else begin
      if (item.valid && item.ready) begin
        rq.cos_incident = item.cos_incident;
        rq.relative_ior = item.relative_ior;
        expected_refl.push_back(fresnel_reflectance(rq));
        n_sent++;
      end
      if (!item.valid || item.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          rq = pending_reqs.pop_front();
          item.valid        <= 1'b1;
          item.cos_incident <= rq.cos_incident;
          item.relative_ior <= rq.relative_ior;
          if (pending_reqs.size() > n_total / 8 && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 5);
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off so the chain
  // fills and the request side backs up.
  int  stall_cnt;
  bit  long_hold_done;
  always @(posedge clk) begin
    if (rst) begin
      result.ready   <= 1'b0;
      stall_cnt      = 0;
      long_hold_done = 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      result.ready <= 1'b0;
    end else if (!long_hold_done && n_sent >= 300) begin
      long_hold_done = 1'b1;
      stall_cnt      = 150;
      result.ready  <= 1'b0;
    end else if (pending_reqs.size() > n_total / 8 && $urandom_range(0, 9) == 0) begin
      stall_cnt     = $urandom_range(0, 4);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  // Result check against the oldest prediction.
  always @(posedge clk) begin
    fresnel_res_t exp_r;
    if (!rst && result.valid && result.ready) begin
      if (expected_refl.size() == 0) begin
        $display("%0t: unexpected result refl=%0d tir=%0b", $time,
                 result.reflectance, result.total_internal);
        n_errors++;
      end else begin
        exp_r = expected_refl.pop_front();
        if (result.reflectance !== exp_r.reflectance) begin
          $display("%0t: reflectance expected %0d actual %0d", $time,
                   exp_r.reflectance, result.reflectance);
          n_errors++;
        end
        if (result.total_internal !== exp_r.total_internal) begin
          $display("%0t: total_internal expected %0b actual %0b", $time,
                   exp_r.total_internal, result.total_internal);
          n_errors++;
        end
      end
    end
  end

  task automatic add_req(input logic [15:0] c, input logic [15:0] eta);
    fresnel_req_t rq;
    rq.cos_incident = c;
    rq.relative_ior = eta;
    pending_reqs.push_back(rq);
  endtask

  initial begin
    int k;
    n_sent   = 0;
    n_errors = 0;
    item.valid        = 1'b0;
    item.cos_incident = '0;
    item.relative_ior = '0;
    result.ready      = 1'b0;

    // Corners: cosine extremes, index 0, 1.0, max, grazing, TIR.
    add_req(16'h0000, 16'h1000);  // grazing at eta=1: g=0, TIR
    add_req(16'h0000, 16'h1800);  // grazing, g>0: saturates
    add_req(16'h7FFF, 16'h1000);
    add_req(16'h8000, 16'h1000);  // -1.0 read as 1.0
    add_req(16'hFFFF, 16'h1000);
    add_req(16'h0001, 16'h1000);
    add_req(16'h7FFF, 16'h0000);
    add_req(16'h8000, 16'h0000);  // eta=0, c=1: g=0
    add_req(16'h0000, 16'h0000);
    add_req(16'h7FFF, 16'hFFFF);
    add_req(16'h8000, 16'hFFFF);
    add_req(16'h0000, 16'hFFFF);
    add_req(16'h8001, 16'h1800);
    add_req(16'h4000, 16'h0A00);  // eta<1 at steep angle: TIR
    add_req(16'h7000, 16'h0C00);
    add_req(16'h2000, 16'h1555);
    add_req(16'h5A82, 16'h1000);
    add_req(16'hC000, 16'h2000);
    add_req(16'h0010, 16'h1001);
    add_req(16'h8000, 16'h0001);

    // Random: mostly realistic indices near 1..3, some full range.
    for (k = 0; k < 1000; k++) begin
      case ($urandom_range(0, 3))
        0:       add_req(16'($urandom()), 16'($urandom()));
        1:       add_req(16'($urandom()), 16'($urandom_range(16'h0800, 16'h1200)));
        default: add_req(16'($urandom()), 16'($urandom_range(16'h1000, 16'h3000)));
      endcase
    end
    n_total = pending_reqs.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (pending_reqs.size() == 0 && n_sent == n_total);
    wait (expected_refl.size() == 0);
    repeat (60) @(posedge clk);
    if (n_errors == 0 && expected_refl.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
